### hw/rtl/fbba_pkg.sv
package fbba_pkg;

  // Capacity of the bitmap and its word organization
  localparam int unsigned MAX_BLOCKS  = 4096;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned WORD_COUNT  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WORD_IDX_W  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned BIT_IDX_W   = $clog2(WORD_BITS);
  localparam int unsigned BLKN_W      = WORD_IDX_W + BIT_IDX_W;
  localparam int unsigned CNT_W       = $clog2(MAX_BLOCKS + 1);

  // Fixed field widths of the request, the result and the register
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned BLK_IN_W    = 12;
  localparam int unsigned FREE_W      = 12;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned CFG_W       = 13;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4096);

  // Width that holds the register, the capacity and a block index
  localparam int unsigned CMP_W0 = (CFG_W > CNT_W) ? CFG_W : CNT_W;
  localparam int unsigned CMP_W  = (CMP_W0 > BLK_IN_W) ? CMP_W0 : BLK_IN_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TEST = 2'd0,
    FUNC_USE  = 2'd1,
    FUNC_FREE = 2'd2,
    FUNC_FIND = 2'd3
  } func_e;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NONE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef enum logic [1:0] {
    RES_RANGE = 2'd0,
    RES_NONE  = 2'd1,
    RES_WORD  = 2'd2
  } res_sel_e;

  typedef struct packed {
    func_e                func;
    logic [BLK_IN_W-1:0]  blk_num;
  } req_t;

  typedef struct packed {
    logic                 in_use;
    logic [FREE_W-1:0]    free_index;
    logic [STAT_W-1:0]    status;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic     capture;    // latch the request
    logic     rd_issue;   // first bitmap read of a request
    logic     scan_next;  // read the next word of a find
    logic     load;       // load the result register
    res_sel_e res_sel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_find;
    logic count_zero;
    logic out_of_range;
    logic hit;        // current word holds a free block in range
    logic last_word;  // current word reaches the end of the count
  } stat_t;

endpackage

### hw/rtl/fbba_ctrl.sv
module fbba_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  output logic           result_valid_o,
  output fbba_pkg::cmd_t cmd_o,
  input  fbba_pkg::stat_t stat_i
);
  import fbba_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_EVAL  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.res_sel = RES_WORD;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.is_find && stat_i.count_zero) begin
          cmd_o.load    = 1'b1;
          cmd_o.res_sel = RES_NONE;
          state_d       = ST_DONE;
        end else if (!stat_i.is_find && stat_i.out_of_range) begin
          cmd_o.load    = 1'b1;
          cmd_o.res_sel = RES_RANGE;
          state_d       = ST_DONE;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d        = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!stat_i.is_find || stat_i.hit) begin
          cmd_o.load    = 1'b1;
          cmd_o.res_sel = RES_WORD;
          state_d       = ST_DONE;
        end else if (stat_i.last_word) begin
          cmd_o.load    = 1'b1;
          cmd_o.res_sel = RES_NONE;
          state_d       = ST_DONE;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_DONE);

endmodule

### hw/rtl/fbba_dpath.sv
module fbba_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fbba_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  fbba_pkg::req_t              req_i,
  input  fbba_pkg::cmd_t              cmd_i,
  output fbba_pkg::stat_t             stat_o,
  output fbba_pkg::rsp_t              rsp_o
);
  import fbba_pkg::*;

  // Bitmap storage: one row per word, a row valid bit stands in for reset
  logic [WORD_BITS-1:0]  mem [WORD_COUNT];
  logic [WORD_COUNT-1:0] row_vld_q;
  logic [WORD_BITS-1:0]  rd_data_q;
  logic                  rd_vld_q;

  logic [CFG_W-1:0]      cfg_q;
  req_t                  req_q;
  logic [WORD_IDX_W-1:0] scan_q, scan_d;
  rsp_t                  res_q, res_d;

  logic [CMP_W-1:0]      cfg_ext, cnt, blk_ext;
  logic [WORD_IDX_W-1:0] req_word;
  logic [BIT_IDX_W-1:0]  req_bit;
  logic                  rd_en;
  logic [WORD_IDX_W-1:0] rd_addr;
  logic [WORD_BITS-1:0]  word;
  logic [CMP_W-1:0]      base, limit;
  logic [WORD_BITS-1:0]  mask, free_bits;
  logic [BIT_IDX_W-1:0]  enc;
  logic [BLKN_W-1:0]     found_blk;
  logic                  wr_en;
  logic [WORD_BITS-1:0]  wr_data;
  logic                  is_mark;

  // Effective count: register limited to capacity
  assign cfg_ext  = CMP_W'(cfg_q);
  assign cnt      = (cfg_ext > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS) : cfg_ext;
  assign blk_ext  = CMP_W'(req_q.blk_num);
  assign req_word = WORD_IDX_W'(req_q.blk_num >> BIT_IDX_W);
  assign req_bit  = req_q.blk_num[BIT_IDX_W-1:0];
  assign is_mark  = (req_q.func == FUNC_USE) || (req_q.func == FUNC_FREE);

  // Read address: the request's word, the first word of a scan, or the next one
  assign rd_en   = cmd_i.rd_issue || cmd_i.scan_next;
  always_comb begin
    scan_d  = scan_q;
    rd_addr = scan_q + 1'b1;
    if (cmd_i.rd_issue) begin
      scan_d  = '0;
      rd_addr = (req_q.func == FUNC_FIND) ? '0 : req_word;
    end else if (cmd_i.scan_next) begin
      scan_d  = scan_q + 1'b1;
    end
  end

  // A row never written reads as all free
  assign word = rd_vld_q ? rd_data_q : '0;

  // Scan: keep only bits below the count, pick the lowest free one
  assign base  = CMP_W'({scan_q, {BIT_IDX_W{1'b0}}});
  assign limit = cnt - base;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = (CMP_W'(i) < limit);
    end
  end

  assign free_bits = ~word & mask;

  always_comb begin
    enc = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        enc = BIT_IDX_W'(i);
      end
    end
  end

  assign found_blk = {scan_q, enc};

  // Mark used or free: read-modify-write of the request's row
  always_comb begin
    wr_data          = word;
    wr_data[req_bit] = (req_q.func == FUNC_USE);
  end
  assign wr_en = cmd_i.load && (cmd_i.res_sel == RES_WORD) && is_mark;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[req_word] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      cfg_q     <= CFG_RESET;
    end else begin
      if (wr_en) begin
        row_vld_q[req_word] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= row_vld_q[rd_addr];
      end
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  // Result: clear every field, then fill in what the outcome calls for
  always_comb begin
    res_d = res_q;
    if (cmd_i.load) begin
      res_d = '0;
      unique case (cmd_i.res_sel)
        RES_RANGE: res_d.status = STAT_RANGE;
        RES_NONE:  res_d.status = STAT_NONE;
        RES_WORD: begin
          res_d.status = STAT_OK;
          if (req_q.func == FUNC_TEST) begin
            res_d.in_use = word[req_bit];
          end
          if (req_q.func == FUNC_FIND) begin
            res_d.free_index = FREE_W'(found_blk);
          end
        end
        default: res_d.status = STAT_NONE;
      endcase
    end
  end

  // Request, scan pointer and result: payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    scan_q <= scan_d;
    res_q  <= res_d;
  end

  assign stat_o.is_find      = (req_q.func == FUNC_FIND);
  assign stat_o.count_zero   = (cnt == '0);
  assign stat_o.out_of_range = (blk_ext >= cnt);
  assign stat_o.hit          = |free_bits;
  assign stat_o.last_word    = (limit <= CMP_W'(WORD_BITS));

  assign rsp_o = res_q;

endmodule

### hw/rtl/free_block_bitmap_allocator.sv
// Channel  | Handshake                  | Payload            | Notes
// ---------+----------------------------+--------------------+----------------------------
// request  | start / busy               | req_i (req_t)      | taken when start & !busy
// result   | result_valid_o             | rsp_o (rsp_t)      | one-cycle strobe, no stall
// config   | cfg_we_i                   | cfg_wdata_i        | managed_blocks, write only
//
// Sequence: test, mark used and mark free go from the accepting edge through the check and
// evaluate states to the done state, which puts the result beat out; the next request can
// go in the cycle after the beat. An out-of-range index, or a find with a count of zero,
// goes from check straight to done. A find stays in evaluate while it scans the bitmap words
// (1 to 128), since the single read port of the bitmap memory delivers one word per cycle.
// Reset: one valid flop per bitmap row clears at once; busy holds until the beat is out.
module free_block_bitmap_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Request channel
  input  logic                       start,
  output logic                       busy,
  input  fbba_pkg::req_t             req_i,
  // Result channel
  output logic                       result_valid_o,
  output fbba_pkg::rsp_t             rsp_o,
  // Configuration: managed_blocks
  input  logic                       cfg_we_i,
  input  logic [fbba_pkg::CFG_W-1:0] cfg_wdata_i
);
  import fbba_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: accept, range check, scan one word per beat, present the result
  fbba_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd),
    .stat_i         (stat)
  );

  // Bitmap memory, count register, word search and result register
  fbba_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .rsp_o       (rsp_o)
  );

endmodule

### tb/bitmap_alloc_checker.sv
module bitmap_alloc_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  fbba_pkg::req_t             req_i,
  input  logic                       result_valid_i,
  input  fbba_pkg::rsp_t             rsp_i,
  input  logic                       cfg_we_i,
  input  logic [fbba_pkg::CFG_W-1:0] cfg_wdata_i,
  output int unsigned                mismatch_count_o,
  output int unsigned                owed_count_o
);
  import fbba_pkg::*;

  logic [MAX_BLOCKS-1:0] used_map = '0;
  logic [CFG_W-1:0]      blocks_cfg = CFG_RESET;
  rsp_t                  awaited_rsp[$];
  rsp_t                  want;
  rsp_t                  next_rsp;
  int unsigned           errors = 0;

  // Apply one request to the shadow bitmap and return the result it must produce.
  function automatic rsp_t alloc_outcome(req_t r);
    int unsigned span;
    logic        hit;
    rsp_t        o;
    span = (blocks_cfg > MAX_BLOCKS) ? MAX_BLOCKS : int'(blocks_cfg);
    o    = '0;
    hit  = 1'b0;
    if (r.func == FUNC_FIND) begin
      o.status = STAT_NONE;
      for (int unsigned b = 0; b < span; b++) begin
        if (!hit && !used_map[b]) begin
          hit          = 1'b1;
          o.free_index = FREE_W'(b);
          o.status     = STAT_OK;
        end
      end
    end else if (r.blk_num >= span) begin
      o.status = STAT_RANGE;
    end else begin
      case (r.func)
        FUNC_TEST: begin
          o.in_use = used_map[r.blk_num];
        end
        FUNC_USE: begin
          used_map[r.blk_num] = 1'b1;
        end
        FUNC_FREE: begin
          used_map[r.blk_num] = 1'b0;
        end
        default: begin
        end
      endcase
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_map   = '0;
      blocks_cfg = CFG_RESET;
      awaited_rsp.delete();
      errors     = 0;
      mismatch_count_o <= 0;
      owed_count_o     <= 0;
    end else begin
      // Retire the result beat before taking a new request on the same edge.
      if (result_valid_i) begin
        if (awaited_rsp.size() == 0) begin
          $display("%0t: result beat with nothing awaited: in_use %0d free_index %0d status %0d",
                   $time, rsp_i.in_use, rsp_i.free_index, rsp_i.status);
          errors++;
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp_i.in_use !== want.in_use) begin
            $display("%0t: in_use expected %0d actual %0d", $time, want.in_use, rsp_i.in_use);
            errors++;
          end
          if (rsp_i.free_index !== want.free_index) begin
            $display("%0t: free_index expected %0d actual %0d",
                     $time, want.free_index, rsp_i.free_index);
            errors++;
          end
          if (rsp_i.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_i.status);
            errors++;
          end
        end
      end
      if (start_i && !busy_i) begin
        next_rsp = alloc_outcome(req_i);
        awaited_rsp.insert(awaited_rsp.size(), next_rsp);
      end
      if (cfg_we_i) begin
        blocks_cfg = cfg_wdata_i;
      end
      mismatch_count_o <= errors;
      owed_count_o     <= awaited_rsp.size();
    end
  end

endmodule

### tb/testbench.sv
module testbench;
  import fbba_pkg::*;

  // Longest correct quiet stretch is a full 128-word find or the longest sender gap
  // that run_phase draws; allow many times either.
  localparam int unsigned STALL_LIMIT = 2000;
  // Drain margin at the end: the slowest request finishes well inside this.
  localparam int unsigned TAIL_CYCLES = 140;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  req_t              req_i = '0;
  logic              result_valid_o;
  rsp_t              rsp_o;
  logic              cfg_we_i = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata_i = CFG_RESET;

  int unsigned       err_count;
  int unsigned       owed_count;
  int unsigned       quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  free_block_bitmap_allocator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  bitmap_alloc_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .req_i            (req_i),
    .result_valid_i   (result_valid_o),
    .rsp_i            (rsp_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_count_o (err_count),
    .owed_count_o     (owed_count)
  );

  // Watchdog: restart on every accepted request or result beat, and fail the test
  // once the quiet count reaches STALL_LIMIT.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it. Leave start high
  // so a following request goes out back to back.
  task automatic issue(input func_e f, input logic [BLK_IN_W-1:0] idx);
    req_t beat;
    beat.func    = f;
    beat.blk_num = idx;
    start <= 1'b1;
    req_i <= beat;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Drop start for the given pause; a pause of zero leaves start as it is.
  task automatic pause(input int unsigned n);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Drop start and hold off until every awaited result beat is out.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (owed_count != 0 || busy) @(posedge clk_i);
  endtask

  // Write managed_blocks, only once the block has gone idle.
  task automatic set_count(input logic [CFG_W-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One random phase: most indexes land in a low window so the bitmap fills up
  // and finds have to scan past used words; the rest span the whole 12-bit
  // field, which also hits out-of-range indexes when the count is small.
  task automatic run_phase(input logic [CFG_W-1:0] cnt, input int unsigned n,
                           input int unsigned idle_pct, input int unsigned window);
    int unsigned           eff;
    int unsigned           span;
    int unsigned           pick;
    func_e                 f;
    logic [BLK_IN_W-1:0]   idx;
    set_count(cnt);
    eff  = (cnt > MAX_BLOCKS) ? MAX_BLOCKS : int'(cnt);
    span = (window < eff) ? window : eff;
    for (int unsigned k = 0; k < n; k++) begin
      if (k == n / 2) begin
        // Let everything in flight come back before going on.
        drain();
      end else if ($urandom_range(99, 0) < idle_pct) begin
        pause($urandom_range(20, 1));
      end
      pick = $urandom_range(99, 0);
      if (pick < 15) begin
        f = FUNC_FIND;
      end else if (pick < 60) begin
        f = FUNC_USE;
      end else if (pick < 80) begin
        f = FUNC_FREE;
      end else begin
        f = FUNC_TEST;
      end
      if (span == 0 || $urandom_range(99, 0) < 15) begin
        idx = BLK_IN_W'($urandom);
      end else begin
        idx = BLK_IN_W'($urandom_range(span - 1, 0));
      end
      issue(f, idx);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty bitmap at the reset count of 4096.
    issue(FUNC_FIND, '0);
    issue(FUNC_TEST, '0);
    issue(FUNC_USE,  '0);
    issue(FUNC_USE,  '1);
    issue(FUNC_TEST, '1);
    issue(FUNC_FIND, '0);
    issue(FUNC_FREE, '0);
    issue(FUNC_FIND, '0);
    issue(FUNC_TEST, '0);

    // Count of one: fill the only block, then find nothing free and flag
    // indexes past the count without touching the bitmap.
    set_count(CFG_W'(1));
    issue(FUNC_USE,  '0);
    issue(FUNC_FIND, '0);
    issue(FUNC_TEST, BLK_IN_W'(1));
    issue(FUNC_FREE, '1);

    // Count of zero: every index out of range, find reports none.
    set_count('0);
    issue(FUNC_FIND, '0);
    issue(FUNC_TEST, '0);
    issue(FUNC_USE,  '0);

    // Count beyond capacity acts as 4096; the top block kept its used bit.
    set_count('1);
    issue(FUNC_TEST, '1);
    issue(FUNC_FREE, '1);
    issue(FUNC_TEST, '1);
    issue(FUNC_FIND, '0);
    issue(FUNC_FREE, '0);

    // Random phases, mixing no idling, heavy idling and light idling.
    run_phase(CFG_W'(4096), 150, 0,  64);
    run_phase(CFG_W'(8),    120, 65, 8);
    run_phase(CFG_W'(1),    40,  14, 1);
    run_phase(CFG_W'(37),   150, 65, 37);
    run_phase('0,           30,  0,  0);
    run_phase('1,           100, 14, 300);
    run_phase(CFG_W'($urandom_range(300, 1)), 100, 0,  300);
    run_phase(CFG_W'($urandom_range(300, 1)), 100, 65, 300);
    run_phase(CFG_W'($urandom_range(300, 1)), 100, 14, 300);
    run_phase(CFG_W'($urandom_range(300, 1)), 100, 65, 300);
    run_phase(CFG_W'(4096), 80,  0,  4096);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0 && owed_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
